FILE: hdl/assert_macros.svh
// Assertion macros used by the orbital evaluator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with active-low reset masking.
`define OWE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also active while reset is asserted.
`define OWE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/owe_pkg.sv
// Package of the orbital wavefunction evaluator: field widths, register indexes,
// control structs and the exponential factor function. No dependencies.
`default_nettype none

package owe_pkg;

    localparam int FIELD_W = 24;
    localparam int PSI_W   = 21;
    localparam int DENS_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CZ      = 3'd5;

    typedef enum logic [1:0] {
        KIND_S = 2'd0,
        KIND_P = 2'd1,
        KIND_D = 2'd2,
        KIND_F = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } t_axis;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_pipe_ctl;

    localparam logic [29:0] EXP_STEP_Q30 = 30'd1073479712;

    // Factor exp(-2^(k-12)) in Q.30, squared k times with rounding.
    function automatic logic [29:0] exp_factor(input int k);
        longint unsigned f;
        f = 64'(EXP_STEP_Q30);
        for (int i = 0; i < k; i++) begin
            f = (f * f + (64'd1 << 29)) >> 30;
        end
        return f[29:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/owe_ifs.sv
// Stream and configuration interfaces of the orbital evaluator.
// Depends on owe_pkg for field widths.
`default_nettype none

interface owe_point_if;
    logic valid;
    logic ready;
    logic signed [owe_pkg::FIELD_W-1:0] pos_x;
    logic signed [owe_pkg::FIELD_W-1:0] pos_y;
    logic signed [owe_pkg::FIELD_W-1:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface owe_result_if;
    logic valid;
    logic ready;
    logic signed [owe_pkg::PSI_W-1:0] psi;
    logic [owe_pkg::DENS_W-1:0] density;
    modport source (output valid, psi, density, input ready);
    modport sink (input valid, psi, density, output ready);
endinterface

interface owe_cfg_if;
    logic valid;
    logic ready;
    logic [owe_pkg::CFG_IDX_W-1:0] index;
    logic [owe_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/owe_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side band.
// Depends on owe_pkg for the pipeline control struct.
`default_nettype none

module owe_isqrt #(
    parameter int W   = 24,
    parameter int SBW = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire owe_pkg::t_pipe_ctl   i_ctl,
    input  wire logic [2*W-1:0]       i_value,
    input  wire logic [SBW-1:0]       i_sb,
    output logic                      o_vld,
    output logic [W-1:0]              o_root,
    output logic [SBW-1:0]            o_sb
);

    localparam int RMW = W + 2;

    logic [2*W-1:0] r_v    [0:W];
    logic [RMW-1:0] r_rem  [0:W];
    logic [W-1:0]   r_root [0:W];
    logic [SBW-1:0] r_sb   [0:W];
    logic [W:0]     r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld[0] <= i_ctl.vld;
        end
        if (i_ctl.adv) begin
            r_v[0]    <= i_value;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sb[0]   <= i_sb;
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [RMW-1:0] w_rem_sh;
        logic [RMW-1:0] w_trial;
        logic           w_take;
        always_comb begin
            w_rem_sh = {r_rem[s][RMW-3:0], r_v[s][2*W-1 -: 2]};
            w_trial  = {r_root[s], 2'b01};
            w_take   = (w_rem_sh >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_ctl.adv) begin
                r_v[s+1]    <= {r_v[s][2*W-3:0], 2'b00};
                r_rem[s+1]  <= w_take ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root[s+1] <= {r_root[s][W-2:0], w_take};
                r_sb[s+1]   <= r_sb[s];
            end
        end
    end

    assign o_vld  = r_vld[W];
    assign o_root = r_root[W];
    assign o_sb   = r_sb[W];

endmodule

`default_nettype wire

FILE: hdl/orbital_wavefunction_evaluator.sv
// Slater-type orbital evaluator: one sample point in, psi and density out per request.
// The pipeline accepts a request every cycle unless stalled; its depth is set by the
// square root, the divide by n and the exponential, each one bit per stage.
// The whole pipeline stalls together when the output register holds a request that is
// not taken. Configuration writes are accepted at any time but must only be made while
// the pipeline is empty. Depends on owe_pkg, owe_ifs, owe_isqrt and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module orbital_wavefunction_evaluator #(
    parameter int COORD_WIDTH   = 24,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    owe_point_if.sink         i_point,
    owe_result_if.source      o_result,
    owe_cfg_if.sink           i_cfg
);

    localparam int CW  = COORD_WIDTH;
    localparam int OFB = OUT_FRAC_BITS;
    localparam int PW  = CW + 31;
    localparam int MW  = PW + 1;
    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (CW - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -(33'sd1 <<< (CW - 1));

    logic [3:0]                 r_quantum;
    owe_pkg::t_kind             r_kind;
    owe_pkg::t_axis             r_axis;
    logic signed [23:0]         r_cx, r_cy, r_cz;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= 4'd1;
            r_kind    <= owe_pkg::KIND_S;
            r_axis    <= owe_pkg::AXIS_NONE;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                owe_pkg::REG_QUANTUM: r_quantum <= i_cfg.data[3:0];
                owe_pkg::REG_KIND:    r_kind    <= owe_pkg::t_kind'(i_cfg.data[1:0]);
                owe_pkg::REG_AXIS:    r_axis    <= owe_pkg::t_axis'(i_cfg.data[1:0]);
                owe_pkg::REG_CX:      r_cx      <= i_cfg.data;
                owe_pkg::REG_CY:      r_cy      <= i_cfg.data;
                owe_pkg::REG_CZ:      r_cz      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic r_out_vld;
    logic w_adv;
    assign w_adv = !r_out_vld || o_result.ready;
    assign i_point.ready = w_adv;

    function automatic logic signed [CW-1:0] sat_diff(input logic signed [23:0] p,
                                                      input logic signed [23:0] c);
        logic signed [32:0] d;
        d = 33'(p) - 33'(c);
        if (d > SAT_HI) begin
            d = SAT_HI;
        end else if (d < SAT_LO) begin
            d = SAT_LO;
        end
        return d[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    // Stage A: offsets.
    logic              r_a_vld;
    logic [CW-1:0]     r_a_mx, r_a_my, r_a_mz;
    logic signed [CW-1:0] r_a_c;
    logic signed [CW-1:0] w_dx, w_dy, w_dz;

    always_comb begin
        w_dx = sat_diff(i_point.pos_x, r_cx);
        w_dy = sat_diff(i_point.pos_y, r_cy);
        w_dz = sat_diff(i_point.pos_z, r_cz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_point.valid;
        end
        if (w_adv) begin
            r_a_mx <= mag_cw(w_dx);
            r_a_my <= mag_cw(w_dy);
            r_a_mz <= mag_cw(w_dz);
            case (r_axis)
                owe_pkg::AXIS_X: r_a_c <= w_dx;
                owe_pkg::AXIS_Y: r_a_c <= w_dy;
                owe_pkg::AXIS_Z: r_a_c <= w_dz;
                default:         r_a_c <= '0;
            endcase
        end
    end

    // Stage B: squares. Stage C: sum.
    logic              r_b_vld, r_c_vld;
    logic [2*CW-1:0]   r_b_sx, r_b_sy, r_b_sz, r_c_sum;
    logic signed [CW-1:0] r_b_c, r_c_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
        if (w_adv) begin
            r_b_sx  <= (2*CW)'(r_a_mx) * (2*CW)'(r_a_mx);
            r_b_sy  <= (2*CW)'(r_a_my) * (2*CW)'(r_a_my);
            r_b_sz  <= (2*CW)'(r_a_mz) * (2*CW)'(r_a_mz);
            r_b_c   <= r_a_c;
            r_c_sum <= r_b_sx + r_b_sy + r_b_sz;
            r_c_c   <= r_b_c;
        end
    end

    owe_pkg::t_pipe_ctl w_sq_ctl;
    logic               w_sq_vld;
    logic [CW-1:0]      w_root;
    logic [CW-1:0]      w_sq_c;

    assign w_sq_ctl.adv = w_adv;
    assign w_sq_ctl.vld = r_c_vld;

    owe_isqrt #(.W(CW), .SBW(CW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_value (r_c_sum),
        .i_sb    (r_c_c),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_sb    (w_sq_c)
    );

    // Divide r by n, one quotient bit per stage.
    logic [CW:0]          r_d_vld;
    logic [CW-1:0]        r_d_num [0:CW];
    logic [CW-1:0]        r_d_q   [0:CW];
    logic [3:0]           r_d_rem [0:CW];
    logic signed [CW-1:0] r_d_c   [0:CW];
    logic [CW:0]          r_d_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_d_vld[0] <= w_sq_vld;
        end
        if (w_adv) begin
            r_d_num[0] <= w_root;
            r_d_q[0]   <= '0;
            r_d_rem[0] <= '0;
            r_d_c[0]   <= w_sq_c;
            r_d_rz[0]  <= (w_root == '0);
        end
    end

    for (genvar s = 0; s < CW; s++) begin : g_div
        logic [4:0] w_sh;
        logic       w_ge;
        always_comb begin
            w_sh = {r_d_rem[s], r_d_num[s][CW-1]};
            w_ge = (w_sh >= {1'b0, r_quantum});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_d_vld[s+1] <= r_d_vld[s];
            end
            if (w_adv) begin
                r_d_num[s+1] <= {r_d_num[s][CW-2:0], 1'b0};
                r_d_q[s+1]   <= {r_d_q[s][CW-2:0], w_ge};
                r_d_rem[s+1] <= w_ge ? 4'(w_sh - {1'b0, r_quantum}) : w_sh[3:0];
                r_d_c[s+1]   <= r_d_c[s];
                r_d_rz[s+1]  <= r_d_rz[s];
            end
        end
    end

    // Exponential: multiply by exp(-2^(k-12)) for each set bit k of t.
    logic [CW:0]          r_x_vld;
    logic [CW-1:0]        r_x_t   [0:CW];
    logic [30:0]          r_x_acc [0:CW];
    logic signed [CW-1:0] r_x_c   [0:CW];
    logic [CW:0]          r_x_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_x_vld[0] <= r_d_vld[CW];
        end
        if (w_adv) begin
            r_x_t[0]   <= r_d_q[CW];
            r_x_acc[0] <= 31'h4000_0000;
            r_x_c[0]   <= r_d_c[CW];
            r_x_rz[0]  <= r_d_rz[CW];
        end
    end

    for (genvar k = 0; k < CW; k++) begin : g_exp
        localparam logic [29:0] FK = owe_pkg::exp_factor(k);
        logic [60:0] w_prod;
        always_comb begin
            w_prod = 61'(r_x_acc[k]) * 61'(FK) + (61'd1 << 29);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_x_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_x_vld[k+1] <= r_x_vld[k];
            end
            if (w_adv) begin
                r_x_t[k+1]   <= r_x_t[k];
                r_x_acc[k+1] <= r_x_t[k][k] ? w_prod[60:30] : r_x_acc[k];
                r_x_c[k+1]   <= r_x_c[k];
                r_x_rz[k+1]  <= r_x_rz[k];
            end
        end
    end

    // Stage P: axis product. Stage Q: rounding to psi. Output: density.
    logic            r_p_vld, r_q_vld;
    logic [PW-1:0]   r_p_prod;
    logic [30:0]     r_p_e;
    logic            r_p_neg, r_p_rz;
    logic signed [owe_pkg::PSI_W-1:0] r_q_psi;
    logic signed [owe_pkg::PSI_W-1:0] r_out_psi;
    logic [owe_pkg::DENS_W-1:0]       r_out_dens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= r_x_vld[CW];
        end
        if (w_adv) begin
            r_p_prod <= PW'(mag_cw(r_x_c[CW])) * PW'(r_x_acc[CW]);
            r_p_e    <= r_x_acc[CW];
            r_p_neg  <= r_x_c[CW][CW-1];
            r_p_rz   <= r_x_rz[CW];
        end
    end

    logic [MW-1:0]  w_mag;
    logic           w_neg;
    logic           w_zero;
    logic signed [owe_pkg::PSI_W-1:0] w_psi;

    always_comb begin
        w_zero = (r_quantum == 4'd0) || (r_kind == owe_pkg::KIND_D)
              || (r_kind == owe_pkg::KIND_F)
              || ((r_kind == owe_pkg::KIND_P)
                  && ((r_axis == owe_pkg::AXIS_NONE) || r_p_rz));
        if (r_kind == owe_pkg::KIND_S) begin
            w_mag = (MW'(r_p_e) + (MW'(1) << (29 - OFB))) >> (30 - OFB);
            w_neg = 1'b0;
        end else begin
            w_mag = (MW'(r_p_prod) + (MW'(1) << (41 - OFB))) >> (42 - OFB);
            w_neg = r_p_neg;
        end
        if (w_zero) begin
            w_psi = '0;
        end else if (w_neg) begin
            w_psi = (w_mag > (MW'(1) << (owe_pkg::PSI_W - 1)))
                  ? {1'b1, {(owe_pkg::PSI_W-1){1'b0}}}
                  : -w_mag[owe_pkg::PSI_W-1:0];
        end else begin
            w_psi = (w_mag > ((MW'(1) << (owe_pkg::PSI_W - 1)) - MW'(1)))
                  ? {1'b0, {(owe_pkg::PSI_W-1){1'b1}}}
                  : w_mag[owe_pkg::PSI_W-1:0];
        end
    end

    logic [owe_pkg::PSI_W-1:0] w_pm;
    logic [2*owe_pkg::PSI_W-1:0] w_sq;
    logic [2*owe_pkg::PSI_W-1:0] w_dens;

    always_comb begin
        w_pm   = r_q_psi[owe_pkg::PSI_W-1] ? (~r_q_psi + 1'b1) : r_q_psi;
        w_sq   = (2*owe_pkg::PSI_W)'(w_pm) * (2*owe_pkg::PSI_W)'(w_pm);
        w_dens = (w_sq + ((2*owe_pkg::PSI_W)'(1) << (OFB - 1))) >> OFB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_q_vld   <= r_p_vld;
            r_out_vld <= r_q_vld;
        end
        if (w_adv) begin
            r_q_psi    <= w_psi;
            r_out_psi  <= r_q_psi;
            r_out_dens <= (w_dens > (2*owe_pkg::PSI_W)'({owe_pkg::DENS_W{1'b1}}))
                        ? {owe_pkg::DENS_W{1'b1}}
                        : w_dens[owe_pkg::DENS_W-1:0];
        end
    end

    assign o_result.valid   = r_out_vld;
    assign o_result.psi     = r_out_psi;
    assign o_result.density = r_out_dens;

    `OWE_ASSERT(a_zero_psi_zero_dens, i_clk, i_rst_n, (r_out_vld && r_out_psi == '0) |-> (r_out_dens == '0), "density nonzero for zero psi")
    `OWE_ASSERT(a_s_positive, i_clk, i_rst_n, (r_out_vld && r_kind == owe_pkg::KIND_S) |-> !r_out_psi[owe_pkg::PSI_W-1], "negative psi for S orbital")
    `OWE_ASSERT(a_n_zero, i_clk, i_rst_n, (r_q_vld && w_adv && r_quantum == 4'd0) |=> (r_out_psi == '0), "nonzero psi with zero quantum number")

endmodule

`default_nettype wire
